>>> hdl/tca_pkg.sv
package tca_pkg;

    localparam int unsigned MAX_SEGMENTS = 1024;
    localparam int unsigned WORST_SLOTS  = 3;

    localparam logic [16:0] Q16_ONE = 17'd65536;

    localparam logic [1:0] REQ_TOKEN      = 2'd0;
    localparam logic [1:0] REQ_SEG_CLOSE  = 2'd1;
    localparam logic [1:0] REQ_TRANSCRIPT = 2'd2;

    localparam logic [1:0] REG_SPECIAL_ID = 2'd0;
    localparam logic [1:0] REG_LOW_THRESH = 2'd1;
    localparam logic [1:0] REG_TIER_EXC   = 2'd2;
    localparam logic [1:0] REG_TIER_GOOD  = 2'd3;

    localparam logic [1:0] TIER_LOW       = 2'd0;
    localparam logic [1:0] TIER_GOOD      = 2'd1;
    localparam logic [1:0] TIER_EXCELLENT = 2'd2;

    localparam int unsigned IDX_TOP_I =
        ((MAX_SEGMENTS - 1) < 1023) ? (MAX_SEGMENTS - 1) : 1023;
    localparam logic [10:0] IDX_TOP = 11'(IDX_TOP_I);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic token;      // apply a token transfer
        logic div_start;  // load divider
        logic seg_mul;    // capture mean, compute confidence product
        logic seg_acc;    // capture confidence, accumulate duration sum, insert worst, clear segment
        logic seg_out;    // load segment report, fold weighted sum
        logic trn_out;    // load transcript report, clear all
        logic sel_trn;    // divider operands from transcript sums
        logic ld_in;      // capture input fields
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;

endpackage

>>> hdl/tca_div.sv
// Restoring divider, one quotient bit a cycle, 51-bit dividend, 35-bit divisor.
module tca_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [50:0] i_num,
    input  logic [34:0] i_den,
    output logic        o_busy,
    output logic [50:0] o_quot
);
    logic [50:0] r_q;
    logic [35:0] r_rem;
    logic [34:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [35:0] w_sh;
    logic [35:0] w_diff;

    assign w_sh   = {r_rem[34:0], r_q[50]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd51;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[35]) begin
                r_rem <= w_diff;
                r_q   <= {r_q[49:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[49:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

>>> hdl/tca_ctrl.sv
module tca_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_req_type,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  tca_pkg::t_sts i_sts,
    output tca_pkg::t_cmd o_cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_trn, n_trn;
    logic       r_ovalid, n_ovalid;
    logic       w_acc;

    assign o_stall = (r_state != ST_IDLE) || (r_ovalid && i_stall);
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_trn    = r_trn;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_cmd.sel_trn = r_trn;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    o_cmd.ld_in = 1'b1;
                    if (i_req_type == tca_pkg::REQ_TOKEN) begin
                        o_cmd.token = 1'b1;
                    end else if (i_req_type == tca_pkg::REQ_SEG_CLOSE) begin
                        n_trn   = 1'b0;
                        n_state = ST_START;
                    end else if (i_req_type == tca_pkg::REQ_TRANSCRIPT) begin
                        n_trn   = 1'b1;
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = r_trn ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.seg_mul = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.seg_acc = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.seg_out = !r_trn;
                    o_cmd.trn_out = r_trn;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_trn    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_trn    <= n_trn;
            r_ovalid <= n_ovalid;
        end
    end

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.seg_out && o_cmd.trn_out))
        else $error("both report loads at once");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("input open while busy");
    a_start_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> i_sts.div_busy)
        else $error("divider did not start");
endmodule

>>> hdl/tca_dp.sv
module tca_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tca_pkg::t_cmd i_cmd,
    output tca_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [16:0]   i_cfg_data,
    input  logic [15:0]   i_token_id,
    input  logic [16:0]   i_token_prob,
    input  logic [16:0]   i_no_speech_prob,
    input  logic [23:0]   i_seg_start_ms,
    input  logic [23:0]   i_seg_end_ms,
    output logic          o_report_kind,
    output logic [16:0]   o_seg_mean_prob,
    output logic [16:0]   o_seg_min_prob,
    output logic [16:0]   o_seg_confidence,
    output logic [16:0]   o_overall_confidence,
    output logic [1:0]    o_tier,
    output logic [1:0]    o_worst_count,
    output logic [9:0]    o_worst_first,
    output logic [9:0]    o_worst_second,
    output logic [9:0]    o_worst_third
);
    logic [15:0] r_special;
    logic [16:0] r_low, r_exc, r_good;
    logic [26:0] r_sum;
    logic [10:0] r_cnt;
    logic [16:0] r_min;
    logic [10:0] r_segs;
    logic [50:0] r_wsum;
    logic [34:0] r_dsum;
    logic [9:0]  r_widx [3];
    logic [16:0] r_wmin [3];
    logic [1:0]  r_fill;
    logic [16:0] r_ns;
    logic [24:0] r_dur;
    logic [16:0] r_mean, r_mn, r_conf;

    logic [16:0] w_p, w_ns, w_mean, w_over, w_ovr;
    logic [27:0] w_sum;
    logic [24:0] w_d;
    logic [33:0] w_cprod;
    logic [41:0] w_wprod;
    logic [51:0] w_wnext;
    logic [35:0] w_dnext;
    logic [9:0]  w_idx;
    logic [1:0]  w_pos;
    logic        w_ins;
    logic        w_busy;
    logic [50:0] w_quot;
    logic [50:0] w_num;
    logic [34:0] w_den;
    logic [1:0]  w_tier;

    assign w_p  = (i_token_prob > tca_pkg::Q16_ONE) ? tca_pkg::Q16_ONE : i_token_prob;
    assign w_ns = (i_no_speech_prob > tca_pkg::Q16_ONE) ? tca_pkg::Q16_ONE
                                                        : i_no_speech_prob;
    assign w_sum = {1'b0, r_sum} + {11'd0, w_p};
    assign w_d   = {1'b0, i_seg_end_ms} - {1'b0, i_seg_start_ms};

    assign w_num = i_cmd.sel_trn ? r_wsum : {24'd0, r_sum};
    assign w_den = i_cmd.sel_trn ? r_dsum : {24'd0, r_cnt};
    assign o_sts.div_busy = w_busy;

    tca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_busy),
        .o_quot  (w_quot)
    );

    assign w_mean = (r_cnt == '0) ? 17'd0
                  : ((w_quot > 51'(tca_pkg::Q16_ONE)) ? tca_pkg::Q16_ONE : w_quot[16:0]);
    assign w_cprod = 34'(r_mean) * 34'(tca_pkg::Q16_ONE - r_ns);
    assign w_wprod = 42'(r_conf) * 42'(r_dur);
    assign w_wnext = {1'b0, r_wsum} + {10'd0, w_wprod};
    assign w_dnext = {1'b0, r_dsum} + {11'd0, r_dur};
    assign w_idx   = (r_segs > tca_pkg::IDX_TOP) ? tca_pkg::IDX_TOP[9:0] : r_segs[9:0];

    always_comb begin
        w_pos = r_fill;
        if (w_pos == 2'd3 && r_mn < r_wmin[2]) w_pos = 2'd2;
        if (w_pos == 2'd2 && r_mn < r_wmin[1]) w_pos = 2'd1;
        if (w_pos == 2'd1 && r_mn < r_wmin[0]) w_pos = 2'd0;
    end
    assign w_ins = (r_mn < r_low) && (w_pos != 2'd3);

    assign w_over = (w_quot > 51'(tca_pkg::Q16_ONE)) ? tca_pkg::Q16_ONE : w_quot[16:0];
    assign w_ovr  = ((r_segs != '0) && (r_dsum != '0)) ? w_over : 17'd0;
    always_comb begin
        w_tier = tca_pkg::TIER_LOW;
        if ((r_segs != '0) && (r_dsum != '0)) begin
            if (w_ovr >= r_exc) w_tier = tca_pkg::TIER_EXCELLENT;
            else if (w_ovr >= r_good) w_tier = tca_pkg::TIER_GOOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_special <= 16'd50257;
            r_low     <= 17'd19661;
            r_exc     <= 17'd55706;
            r_good    <= 17'd42598;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tca_pkg::REG_SPECIAL_ID: r_special <= i_cfg_data[15:0];
                tca_pkg::REG_LOW_THRESH: r_low     <= i_cfg_data;
                tca_pkg::REG_TIER_EXC:   r_exc     <= i_cfg_data;
                tca_pkg::REG_TIER_GOOD:  r_good    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_ns  <= w_ns;
            r_dur <= w_d[24] || (w_d == '0) ? 25'd1 : w_d;
        end
        if (i_cmd.seg_mul) begin
            r_mean <= w_mean;
            r_mn   <= (r_cnt == '0) ? 17'd0 : r_min;
        end
        if (i_cmd.seg_acc) begin
            r_conf <= w_cprod[32:16];
        end
    end

    // r_conf is registered at seg_acc, so the weighted sum is folded at seg_out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.trn_out) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_min  <= tca_pkg::Q16_ONE;
            r_segs <= '0;
            r_wsum <= '0;
            r_dsum <= '0;
            r_fill <= '0;
            for (int k = 0; k < 3; k++) begin
                r_widx[k] <= '0;
                r_wmin[k] <= '0;
            end
        end else begin
            if (i_cmd.token && (i_token_id < r_special)) begin
                r_sum <= w_sum[27] ? '1 : w_sum[26:0];
                if (r_cnt != '1) r_cnt <= r_cnt + 11'd1;
                if (w_p < r_min) r_min <= w_p;
            end
            if (i_cmd.seg_acc) begin
                r_dsum <= w_dnext[35] ? '1 : w_dnext[34:0];
                if (w_ins) begin
                    for (int k = 2; k > 0; k--) begin
                        if (2'(k) > w_pos) begin
                            r_widx[k] <= r_widx[k-1];
                            r_wmin[k] <= r_wmin[k-1];
                        end
                    end
                    r_widx[w_pos] <= w_idx;
                    r_wmin[w_pos] <= r_mn;
                    if (r_fill != 2'd3) r_fill <= r_fill + 2'd1;
                end
                if (r_segs != '1) r_segs <= r_segs + 11'd1;
                r_sum <= '0;
                r_cnt <= '0;
                r_min <= tca_pkg::Q16_ONE;
            end
            if (i_cmd.seg_out) begin
                r_wsum <= w_wnext[51] ? '1 : w_wnext[50:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_out) begin
            o_report_kind        <= 1'b0;
            o_seg_mean_prob      <= r_mean;
            o_seg_min_prob       <= r_mn;
            o_seg_confidence     <= r_conf;
            o_overall_confidence <= '0;
            o_tier               <= tca_pkg::TIER_LOW;
            o_worst_count        <= '0;
            o_worst_first        <= '0;
            o_worst_second       <= '0;
            o_worst_third        <= '0;
        end else if (i_cmd.trn_out) begin
            o_report_kind        <= 1'b1;
            o_seg_mean_prob      <= '0;
            o_seg_min_prob       <= '0;
            o_seg_confidence     <= '0;
            o_overall_confidence <= w_ovr;
            o_tier               <= w_tier;
            o_worst_count        <= r_fill;
            o_worst_first        <= (r_fill > 2'd0) ? r_widx[0] : '0;
            o_worst_second       <= (r_fill > 2'd1) ? r_widx[1] : '0;
            o_worst_third        <= (r_fill > 2'd2) ? r_widx[2] : '0;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd3) else $error("worst fill out of range");
    a_worst_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill >= 2'd2) |-> (r_wmin[0] <= r_wmin[1]))
        else $error("worst list unordered");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.trn_out |=> (r_segs == '0 && r_fill == '0))
        else $error("transcript close did not clear");
endmodule

>>> hdl/transcript_confidence_aggregator.sv
// Transcript confidence aggregator.
// Input channel (i_valid/o_stall): one transfer per token, segment close or
// transcript close item, chosen by i_req_type. Token transfers give no result
// and leave the controller idle, so they do not close the input.
// Output channel (o_valid/i_stall): one report per segment or transcript
// close. Both kinds of close run through the shared 51-step restoring divider
// that forms the segment mean and the duration-weighted overall confidence;
// a segment close then also forms its confidence and accumulates.
// One close is processed at a time; the input is stalled until its report is
// loaded into the output register.
// While the receiver stalls, the report holds and a finished close waits in
// its last step; token transfers are still taken as long as no close is in
// flight and the output register is free or being drained.
// Reset (synchronous, active low) restores the register defaults and clears
// all segment and transcript accumulators.
// Configuration writes (i_cfg_we) take effect at once; write only while idle.
module transcript_confidence_aggregator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_token_id,
    input  logic [16:0] i_token_prob,
    input  logic [16:0] i_no_speech_prob,
    input  logic [23:0] i_seg_start_ms,
    input  logic [23:0] i_seg_end_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_report_kind,
    output logic [16:0] o_seg_mean_prob,
    output logic [16:0] o_seg_min_prob,
    output logic [16:0] o_seg_confidence,
    output logic [16:0] o_overall_confidence,
    output logic [1:0]  o_tier,
    output logic [1:0]  o_worst_count,
    output logic [9:0]  o_worst_first,
    output logic [9:0]  o_worst_second,
    output logic [9:0]  o_worst_third
);
    tca_pkg::t_cmd w_cmd;
    tca_pkg::t_sts w_sts;

    // Sequence each close: divide, confidence and accumulate (segment close only), report.
    tca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tca_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_token_id           (i_token_id),
        .i_token_prob         (i_token_prob),
        .i_no_speech_prob     (i_no_speech_prob),
        .i_seg_start_ms       (i_seg_start_ms),
        .i_seg_end_ms         (i_seg_end_ms),
        .o_report_kind        (o_report_kind),
        .o_seg_mean_prob      (o_seg_mean_prob),
        .o_seg_min_prob       (o_seg_min_prob),
        .o_seg_confidence     (o_seg_confidence),
        .o_overall_confidence (o_overall_confidence),
        .o_tier               (o_tier),
        .o_worst_count        (o_worst_count),
        .o_worst_first        (o_worst_first),
        .o_worst_second       (o_worst_second),
        .o_worst_third        (o_worst_third)
    );
endmodule

>>> tb/sv/tca_report_checker.sv
// Watches both channels of the aggregator, predicts each report from the
// accepted input transfers and compares the reports field by field.
module tca_report_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_token_id,
    input  logic [16:0] i_token_prob,
    input  logic [16:0] i_no_speech_prob,
    input  logic [23:0] i_seg_start_ms,
    input  logic [23:0] i_seg_end_ms,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_report_kind,
    input  logic [16:0] i_seg_mean_prob,
    input  logic [16:0] i_seg_min_prob,
    input  logic [16:0] i_seg_confidence,
    input  logic [16:0] i_overall_confidence,
    input  logic [1:0]  i_tier,
    input  logic [1:0]  i_worst_count,
    input  logic [9:0]  i_worst_first,
    input  logic [9:0]  i_worst_second,
    input  logic [9:0]  i_worst_third,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        kind;
        logic [16:0] mean;
        logic [16:0] minp;
        logic [16:0] conf;
        logic [16:0] overall;
        logic [1:0]  tier;
        logic [1:0]  wcnt;
        logic [9:0]  w0;
        logic [9:0]  w1;
        logic [9:0]  w2;
    } t_report;

    localparam longint unsigned SUM_TOP  = (64'd1 << 27) - 1;
    localparam longint unsigned WSUM_TOP = (64'd1 << 51) - 1;
    localparam longint unsigned DSUM_TOP = (64'd1 << 35) - 1;

    t_report report_q[$];

    logic [15:0] special_id;
    logic [16:0] low_thresh, exc_level, good_level;

    longint unsigned prob_sum, wconf_sum, dur_sum;
    int unsigned     tok_count, seg_count, worst_fill;
    logic [16:0]     prob_min;
    int unsigned     worst_idx[tca_pkg::WORST_SLOTS];
    logic [16:0]     worst_min[tca_pkg::WORST_SLOTS];

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                                longint unsigned top);
        longint unsigned s;
        s = a + b;
        return (s > top) ? top : s;
    endfunction

    function automatic logic [16:0] clamp_q16(longint unsigned v);
        return (v > 65536) ? tca_pkg::Q16_ONE : 17'(v);
    endfunction

    task automatic clear_segment();
        prob_sum  = 0;
        tok_count = 0;
        prob_min  = tca_pkg::Q16_ONE;
    endtask

    task automatic clear_transcript();
        clear_segment();
        seg_count  = 0;
        wconf_sum  = 0;
        dur_sum    = 0;
        worst_fill = 0;
        for (int k = 0; k < tca_pkg::WORST_SLOTS; k++) begin
            worst_idx[k] = 0;
            worst_min[k] = 0;
        end
    endtask

    // Sorted insert; ties keep the earlier segment ahead.
    task automatic insert_worst(int unsigned idx, logic [16:0] mn);
        int pos;
        pos = worst_fill;
        while (pos > 0 && mn < worst_min[pos-1]) pos--;
        if (pos < tca_pkg::WORST_SLOTS) begin
            for (int k = tca_pkg::WORST_SLOTS - 1; k > pos; k--) begin
                worst_idx[k] = worst_idx[k-1];
                worst_min[k] = worst_min[k-1];
            end
            worst_idx[pos] = idx;
            worst_min[pos] = mn;
            if (worst_fill < tca_pkg::WORST_SLOTS) worst_fill++;
        end
    endtask

    task automatic apply_transfer();
        t_report         r;
        logic [16:0]     p, ns;
        longint          d;
        longint unsigned dur;
        int unsigned     idx, cnt;
        r = '0;
        case (i_req_type)
            tca_pkg::REQ_TOKEN: begin
                p = clamp_q16(i_token_prob);
                if (i_token_id < special_id) begin
                    prob_sum = sat_add(prob_sum, p, SUM_TOP);
                    if (tok_count < 2047) tok_count++;
                    if (p < prob_min) prob_min = p;
                end
            end
            tca_pkg::REQ_SEG_CLOSE: begin
                ns  = clamp_q16(i_no_speech_prob);
                d   = longint'(i_seg_end_ms) - longint'(i_seg_start_ms);
                dur = (d < 1) ? 1 : d;
                if (tok_count > 0) begin
                    r.mean = clamp_q16(prob_sum / tok_count);
                    r.minp = prob_min;
                end
                r.conf = 17'((longint'(r.mean) * (65536 - longint'(ns))) >> 16);
                wconf_sum = sat_add(wconf_sum, longint'(r.conf) * dur, WSUM_TOP);
                dur_sum   = sat_add(dur_sum, dur, DSUM_TOP);
                idx = (seg_count > tca_pkg::IDX_TOP_I) ? tca_pkg::IDX_TOP_I : seg_count;
                if (r.minp < low_thresh) insert_worst(idx, r.minp);
                if (seg_count < 2047) seg_count++;
                clear_segment();
                report_q.insert(report_q.size(), r);
            end
            tca_pkg::REQ_TRANSCRIPT: begin
                r.kind = 1'b1;
                r.tier = tca_pkg::TIER_LOW;
                if (seg_count > 0 && dur_sum > 0) begin
                    r.overall = clamp_q16(wconf_sum / dur_sum);
                    if (r.overall >= exc_level)       r.tier = tca_pkg::TIER_EXCELLENT;
                    else if (r.overall >= good_level) r.tier = tca_pkg::TIER_GOOD;
                end
                cnt    = (worst_fill > 3) ? 3 : worst_fill;
                r.wcnt = 2'(cnt);
                if (cnt > 0) r.w0 = 10'(worst_idx[0]);
                if (cnt > 1) r.w1 = 10'(worst_idx[1]);
                if (cnt > 2) r.w2 = 10'(worst_idx[2]);
                clear_transcript();
                report_q.insert(report_q.size(), r);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    task automatic compare_report();
        t_report e;
        if (report_q.size() == 0) begin
            $error("report with no prediction waiting (kind %0d)", i_report_kind);
            o_fail_count++;
        end else begin
            e = report_q.pop_front();
            check_field("report_kind", e.kind, i_report_kind);
            check_field("seg_mean_prob", e.mean, i_seg_mean_prob);
            check_field("seg_min_prob", e.minp, i_seg_min_prob);
            check_field("seg_confidence", e.conf, i_seg_confidence);
            check_field("overall_confidence", e.overall, i_overall_confidence);
            check_field("tier", e.tier, i_tier);
            check_field("worst_count", e.wcnt, i_worst_count);
            check_field("worst_first", e.w0, i_worst_first);
            check_field("worst_second", e.w1, i_worst_second);
            check_field("worst_third", e.w2, i_worst_third);
        end
    endtask

    initial begin
        o_fail_count = 0;
        special_id   = 16'd50257;
        low_thresh   = 17'd19661;
        exc_level    = 17'd55706;
        good_level   = 17'd42598;
        clear_transcript();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            special_id = 16'd50257;
            low_thresh = 17'd19661;
            exc_level  = 17'd55706;
            good_level = 17'd42598;
            clear_transcript();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tca_pkg::REG_SPECIAL_ID: special_id = i_cfg_data[15:0];
                    tca_pkg::REG_LOW_THRESH: low_thresh = i_cfg_data;
                    tca_pkg::REG_TIER_EXC:   exc_level  = i_cfg_data;
                    tca_pkg::REG_TIER_GOOD:  good_level = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) compare_report();
            if (i_valid && !i_in_stall) apply_transfer();
        end
        o_pending = report_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Stimulus and verdict for the transcript confidence aggregator. The checker
// beside the block does all prediction and comparison.
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [15:0] i_token_id;
    logic [16:0] i_token_prob;
    logic [16:0] i_no_speech_prob;
    logic [23:0] i_seg_start_ms;
    logic [23:0] i_seg_end_ms;
    logic        o_valid;
    logic        i_stall;
    logic        o_report_kind;
    logic [16:0] o_seg_mean_prob;
    logic [16:0] o_seg_min_prob;
    logic [16:0] o_seg_confidence;
    logic [16:0] o_overall_confidence;
    logic [1:0]  o_tier;
    logic [1:0]  o_worst_count;
    logic [9:0]  o_worst_first;
    logic [9:0]  o_worst_second;
    logic [9:0]  o_worst_third;

    int          fail_count;
    int          pending;
    int unsigned cycle_count;
    bit          hold_off;   // long receiver hold-off requested by the stimulus

    // Generous: ~550 transfers, each close running through the divider, plus long gaps/stalls.
    localparam int unsigned CYCLE_LIMIT = 600000;

    // Request code the block must ignore.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    transcript_confidence_aggregator u_top (.*);

    tca_report_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_req_type(i_req_type),
        .i_token_id(i_token_id), .i_token_prob(i_token_prob),
        .i_no_speech_prob(i_no_speech_prob), .i_seg_start_ms(i_seg_start_ms),
        .i_seg_end_ms(i_seg_end_ms), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_report_kind(o_report_kind), .i_seg_mean_prob(o_seg_mean_prob),
        .i_seg_min_prob(o_seg_min_prob), .i_seg_confidence(o_seg_confidence),
        .i_overall_confidence(o_overall_confidence), .i_tier(o_tier),
        .i_worst_count(o_worst_count), .i_worst_first(o_worst_first),
        .i_worst_second(o_worst_second), .i_worst_third(o_worst_third),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up at the cycle limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall, mostly short; long stretch while hold_off is set.
    always @(posedge i_clk) begin
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_off) i_stall <= 1'b1;
        else if (cycle_count % 3000 < 1200) i_stall <= 1'b0;   // stall-free stretch
        else if (r < 25) i_stall <= 1'b1;
        else if (r < 27) i_stall <= ($urandom_range(0, 3) != 0);
        else i_stall <= 1'b0;
    end

    task automatic idle_gap();
        int unsigned n;
        if ($urandom_range(0, 99) < 60) n = 0;
        else if ($urandom_range(0, 99) < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 60);
        repeat (n) @(posedge i_clk);
    endtask

    // Offer one transfer and hold it until accepted.
    task automatic send(logic [1:0] req, logic [15:0] id, logic [16:0] prob,
                        logic [16:0] ns, logic [23:0] t0, logic [23:0] t1);
        i_valid          <= 1'b1;
        i_req_type       <= req;
        i_token_id       <= id;
        i_token_prob     <= prob;
        i_no_speech_prob <= ns;
        i_seg_start_ms   <= t0;
        i_seg_end_ms     <= t1;
        do @(posedge i_clk); while (o_stall);
        if ($urandom_range(0, 99) < 40) begin
            i_valid <= 1'b0;
            idle_gap();
        end
    endtask

    task automatic send_token(logic [15:0] id, logic [16:0] prob);
        send(tca_pkg::REQ_TOKEN, id, prob, 17'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic send_close(logic [16:0] ns, logic [23:0] t0, logic [23:0] t1);
        send(tca_pkg::REQ_SEG_CLOSE, 16'($urandom), 17'($urandom), ns, t0, t1);
    endtask

    task automatic send_transcript();
        send(tca_pkg::REQ_TRANSCRIPT, 16'($urandom), 17'($urandom), 17'($urandom),
             24'($urandom), 24'($urandom));
    endtask

    // Drain all reports, then let the block settle before a register write.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [16:0] rand_prob();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return 17'd0;
        if (r < 10) return tca_pkg::Q16_ONE;
        if (r < 13) return 17'($urandom_range(65537, 131071));
        if (r < 40) return 17'($urandom_range(0, 20000));
        return 17'($urandom_range(0, 65536));
    endfunction

    task automatic random_segment();
        int unsigned ntok;
        logic [23:0] t0;
        ntok = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (ntok) begin
            if ($urandom_range(0, 9) == 0) send_token(16'($urandom), rand_prob());
            else send_token(16'($urandom_range(0, 50000)), rand_prob());
        end
        t0 = 24'($urandom);
        if ($urandom_range(0, 9) == 0) send_close(rand_prob(), t0, 24'($urandom));
        else send_close(rand_prob(), t0, 24'(t0 + $urandom_range(0, 5000)));
    endtask

    initial begin
        cycle_count      = 0;
        hold_off         = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = tca_pkg::REG_SPECIAL_ID;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_req_type       = tca_pkg::REQ_TOKEN;
        i_token_id       = '0;
        i_token_prob     = '0;
        i_no_speech_prob = '0;
        i_seg_start_ms   = '0;
        i_seg_end_ms     = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty transcript, empty segment, field extremes, specials.
        send_transcript();
        send_close(17'd0, 24'd100, 24'd50);              // no tokens, negative duration
        send_token(16'd0, tca_pkg::Q16_ONE);
        send_token(16'd50256, 17'd0);
        send_token(16'd50257, 17'd5);                    // skipped: at special id
        send_token(16'hFFFF, 17'h1FFFF);                 // skipped
        send_token(16'd7, 17'h1FFFF);                    // above one, taken as one
        send_close(17'h1FFFF, 24'd0, 24'hFFFFFF);
        send_token(16'd3, 17'd1000);
        send_close(17'd0, 24'd5, 24'd5);                 // zero duration
        send_token(16'd3, 17'd1000);                     // tie with earlier minimum
        send_close(tca_pkg::Q16_ONE, 24'hFFFFFF, 24'd0);
        send_token(16'd4, 17'd10);
        send_close(17'd0, 24'd0, 24'd1000);
        send_token(16'd9, 17'd500);
        send_close(17'd32768, 24'd0, 24'd2000);          // sixth candidate
        send_token(16'd1, 17'd123);
        send(REQ_UNKNOWN, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF);  // ignored
        send_transcript();                               // token left unclosed
        send_transcript();
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(tca_pkg::REG_SPECIAL_ID, 17'd0);
                    write_reg(tca_pkg::REG_LOW_THRESH, 17'd0);
                    write_reg(tca_pkg::REG_TIER_EXC, 17'd0);
                    write_reg(tca_pkg::REG_TIER_GOOD, 17'd0);
                end
                1: begin
                    write_reg(tca_pkg::REG_SPECIAL_ID, 17'hFFFF);
                    write_reg(tca_pkg::REG_LOW_THRESH, tca_pkg::Q16_ONE);
                    write_reg(tca_pkg::REG_TIER_EXC, tca_pkg::Q16_ONE);
                    write_reg(tca_pkg::REG_TIER_GOOD, tca_pkg::Q16_ONE);
                end
                2: begin
                    write_reg(tca_pkg::REG_SPECIAL_ID, 17'd50257);
                    write_reg(tca_pkg::REG_LOW_THRESH, 17'd40000);
                    write_reg(tca_pkg::REG_TIER_EXC, 17'd30000);
                    write_reg(tca_pkg::REG_TIER_GOOD, 17'd10000);
                end
                default: begin
                    write_reg(tca_pkg::REG_SPECIAL_ID, 17'($urandom_range(30000, 65535)));
                    write_reg(tca_pkg::REG_LOW_THRESH, 17'($urandom_range(0, 65536)));
                    write_reg(tca_pkg::REG_TIER_EXC, 17'($urandom_range(20000, 65536)));
                    write_reg(tca_pkg::REG_TIER_GOOD, 17'($urandom_range(0, 40000)));
                end
            endcase
            for (int t = 0; t < 5; t++) begin
                int unsigned nseg;
                nseg = $urandom_range(0, 5);
                for (int s = 0; s < nseg; s++) random_segment();
                if ($urandom_range(0, 9) == 0)
                    send(REQ_UNKNOWN, 16'($urandom), 17'($urandom), 17'($urandom),
                         24'($urandom), 24'($urandom));
                send_transcript();
            end
            // Receiver holds off long while tokens and closes keep coming.
            if (phase == 2) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (400) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    begin
                        repeat (3) random_segment();
                    end
                join
            end
            wait_idle();
        end

        // A longer transcript, long enough for segment index growth.
        write_reg(tca_pkg::REG_LOW_THRESH, tca_pkg::Q16_ONE);
        for (int s = 0; s < 20; s++) random_segment();
        send_transcript();

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
